// File: hdl/aes_pkg.sv
// AES package: round types, S-box tables and GF(2^8) helper functions.
// No dependencies; used by every module of the cipher.
package aes_pkg;

    typedef logic [127:0] t_block;

    localparam int unsigned ROUND_COUNT = 10;

    localparam logic [0:0] OP_ENCRYPT = 1'b0;
    localparam logic [0:0] OP_DECRYPT = 1'b1;

    localparam logic [0:0] CFG_KEY_UPPER = 1'b0;
    localparam logic [0:0] CFG_KEY_LOWER = 1'b1;

    typedef struct packed {
        logic   valid;
        logic   decrypt;
        t_block data;
    } t_stage;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_BOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Byte k of a block, byte 0 in the most significant position.
    function automatic logic [7:0] get_byte(input t_block b, input int unsigned k);
        get_byte = b[127 - 8*k -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block sub_shift_fwd(input t_block b);
        t_block t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = FWD_BOX[get_byte(b, r + 4*((c + r) % 4))];
            end
        end
        sub_shift_fwd = t;
    endfunction

    function automatic t_block sub_shift_inv(input t_block b);
        t_block t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = INV_BOX[get_byte(b, r + 4*c)];
            end
        end
        sub_shift_inv = t;
    endfunction

    function automatic t_block mix_fwd(input t_block b);
        t_block t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(b, 4*c);
            a1 = get_byte(b, 4*c + 1);
            a2 = get_byte(b, 4*c + 2);
            a3 = get_byte(b, 4*c + 3);
            t[127 - 8*(4*c)     -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[127 - 8*(4*c + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[127 - 8*(4*c + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_fwd = t;
    endfunction

    // Inverse mix: a pre-step with {05,00,04,00}-style correction, then the forward mix.
    function automatic t_block mix_inv(input t_block b);
        t_block t;
        logic [7:0] a0, a1, a2, a3, u, v;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(b, 4*c);
            a1 = get_byte(b, 4*c + 1);
            a2 = get_byte(b, 4*c + 2);
            a3 = get_byte(b, 4*c + 3);
            u = xtime(xtime(a0 ^ a2));
            v = xtime(xtime(a1 ^ a3));
            t[127 - 8*(4*c)     -: 8] = a0 ^ u;
            t[127 - 8*(4*c + 1) -: 8] = a1 ^ v;
            t[127 - 8*(4*c + 2) -: 8] = a2 ^ u;
            t[127 - 8*(4*c + 3) -: 8] = a3 ^ v;
        end
        mix_inv = mix_fwd(t);
    endfunction

endpackage

// File: hdl/aes_key_cell.sv
// One cell of the key schedule chain: derives round key n+1 from round key n
// and registers it. Depends on aes_pkg.
module aes_key_cell #(
    parameter int unsigned ROUND = 1
) (
    input  logic            i_clk,
    input  aes_pkg::t_block i_key,
    output aes_pkg::t_block o_key
);
    import aes_pkg::*;

    logic [31:0] w0, w1, w2, w3, t;
    t_block      n_key;
    t_block      r_key;

    always_comb begin
        w0 = i_key[127:96];
        w1 = i_key[95:64];
        w2 = i_key[63:32];
        w3 = i_key[31:0];
        t  = {FWD_BOX[w3[23:16]] ^ RCON[ROUND - 1], FWD_BOX[w3[15:8]],
              FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
        n_key[127:96] = w0 ^ t;
        n_key[95:64]  = w0 ^ t ^ w1;
        n_key[63:32]  = w0 ^ t ^ w1 ^ w2;
        n_key[31:0]   = w0 ^ t ^ w1 ^ w2 ^ w3;
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

// File: hdl/aes_round_cell.sv
// One pipeline cell of the cipher chain: one encrypt or decrypt round and its register.
// Depends on aes_pkg.
module aes_round_cell #(
    parameter bit LAST = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  aes_pkg::t_stage i_stage,
    input  aes_pkg::t_block i_enc_key,
    input  aes_pkg::t_block i_dec_key,
    output aes_pkg::t_stage o_stage
);
    import aes_pkg::*;

    t_stage r_stage;
    t_block n_data;

    always_comb begin
        if (i_stage.decrypt == OP_DECRYPT) begin
            n_data = sub_shift_inv(i_stage.data) ^ i_dec_key;
            if (!LAST) begin
                n_data = mix_inv(n_data);
            end
        end else begin
            n_data = sub_shift_fwd(i_stage.data);
            if (!LAST) begin
                n_data = mix_fwd(n_data);
            end
            n_data = n_data ^ i_enc_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage.valid <= i_stage.valid;
        end
        if (i_adv) begin
            r_stage.decrypt <= i_stage.decrypt;
            r_stage.data    <= n_data;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: hdl/aes128_block_cipher.sv
// Top level of the AES-128 cipher: key registers, key schedule and the round chain.
// Depends on aes_pkg, aes_key_cell and aes_round_cell.

// AES-128 encrypt/decrypt pipeline. One block transaction is accepted every
// cycle while the output side takes results and the keys have settled;
// a block passes one input register for the first AddRoundKey, which loads
// at the accepting edge itself, then ten round cells. The whole chain
// advances together, so a stalled output holds every stage and input ready
// follows output ready whenever the last stage holds a result. Round keys
// are expanded by a registered chain of key cells, one round key per cycle;
// input ready stays low after every key write and after reset until the
// last round key has settled. The two key registers are meant to be written
// only while the pipeline is empty.
module aes128_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [63:0] i_data_upper,
    input  logic [63:0] i_data_lower,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_out_upper,
    output logic [63:0] o_out_lower,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import aes_pkg::*;

    logic [63:0] r_key_upper, r_key_lower;
    logic [3:0]  r_settle;
    t_block      rkey [ROUND_COUNT + 1];
    t_stage      stage [ROUND_COUNT + 1];
    t_stage      r_in;
    logic        adv;
    logic        key_ready;

    // Configuration writes are always taken; an index is one bit wide so
    // both codes name a register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_UPPER: r_key_upper <= i_cfg_data;
                CFG_KEY_LOWER: r_key_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Settle counter: reloaded by reset and by every key write, it holds off
    // input blocks until the last round key is valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 4'(ROUND_COUNT);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_settle <= 4'(ROUND_COUNT);
        end else if (r_settle != 4'd0) begin
            r_settle <= r_settle - 4'd1;
        end
    end

    assign key_ready = (r_settle == 4'd0);

    // Key schedule: a row of registered cells, each producing the next round key.
    assign rkey[0] = {r_key_upper, r_key_lower};
    for (genvar g = 1; g <= ROUND_COUNT; g++) begin : g_key
        aes_key_cell #(.ROUND(g)) u_key (
            .i_clk (i_clk),
            .i_key (rkey[g - 1]),
            .o_key (rkey[g])
        );
    end

    // The chain moves whenever the last stage is empty or being drained.
    assign adv     = !stage[ROUND_COUNT].valid || i_ready;
    assign o_ready = adv && key_ready;

    // Input register applies the initial AddRoundKey for either direction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (adv) begin
            r_in.valid <= i_valid && key_ready;
        end
        if (adv) begin
            r_in.decrypt <= i_opcode;
            r_in.data    <= {i_data_upper, i_data_lower} ^
                            ((i_opcode == OP_DECRYPT) ? rkey[ROUND_COUNT] : rkey[0]);
        end
    end

    assign stage[0] = r_in;

    // Encryption round g uses key g; decryption in the same cell uses key 10-g.
    for (genvar g = 1; g <= ROUND_COUNT; g++) begin : g_round
        aes_round_cell #(.LAST(g == ROUND_COUNT)) u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_stage   (stage[g - 1]),
            .i_enc_key (rkey[g]),
            .i_dec_key (rkey[ROUND_COUNT - g]),
            .o_stage   (stage[g])
        );
    end

    assign o_valid     = stage[ROUND_COUNT].valid;
    assign o_out_upper = stage[ROUND_COUNT].data[127:64];
    assign o_out_lower = stage[ROUND_COUNT].data[63:0];

endmodule

// File: test/tb_aes128_block_cipher.sv
// Testbench for the AES-128 block cipher: directed vectors, then random blocks
// under random idling, checked against an in-bench cipher model.
// Depends on aes_pkg and aes128_block_cipher.

module tb_aes128_block_cipher;
    import aes_pkg::*;

    // Scoreboard of expected cipher outputs, oldest first.
    class cipher_scoreboard;
        logic [127:0] pending[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        function void note_block(logic [127:0] expected);
            pending.push_back(expected);
        endfunction

        function void check_block(logic [63:0] got_upper, logic [63:0] got_lower);
            logic [127:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h_%h", $time, got_upper, got_lower);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want[127:64] !== got_upper) begin
                $display("%0t: out_upper expected %h actual %h", $time, want[127:64],
                    got_upper);
                errors++;
            end
            if (want[63:0] !== got_lower) begin
                $display("%0t: out_lower expected %h actual %h", $time, want[63:0],
                    got_lower);
                errors++;
            end
        endfunction
    endclass

    localparam int NUM_RANDOM = 650;
    localparam int LATENCY    = 11;
    localparam int CYCLE_CAP  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_opcode;
    logic [63:0] i_data_upper;
    logic [63:0] i_data_lower;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_out_upper;
    logic [63:0] o_out_lower;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    aes128_block_cipher u_dut (.*);

    cipher_scoreboard board;

    // Key held by the model, mirrored from every register write.
    logic [127:0] model_key;
    int           cycle_count;
    bit           calm_mode;     // no random idling on either side
    int           hold_off;      // receiver hold-off cycles still to wait

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- Cipher model ----------------

    function automatic logic [7:0] byte_of(logic [127:0] b, int k);
        return b[127 - 8*k -: 8];
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] x, logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (y[0]) acc ^= x;
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
            y = y >> 1;
        end
        return acc;
    endfunction

    // Round keys, round 0 in entry 0, bytes in state order.
    function automatic void derive_round_keys(logic [127:0] key,
                                              output logic [127:0] rk[11]);
        logic [7:0] w[176];
        logic [7:0] t[4];
        logic [7:0] s;
        for (int k = 0; k < 16; k++) w[k] = byte_of(key, k);
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) t[j] = w[i - 4 + j];
            if (i % 16 == 0) begin
                s = t[0];
                t[0] = FWD_BOX[t[1]] ^ RCON[i/16 - 1];
                t[1] = FWD_BOX[t[2]];
                t[2] = FWD_BOX[t[3]];
                t[3] = FWD_BOX[s];
            end
            for (int j = 0; j < 4; j++) w[i + j] = w[i + j - 16] ^ t[j];
        end
        for (int r = 0; r < 11; r++)
            for (int k = 0; k < 16; k++) rk[r][127 - 8*k -: 8] = w[16*r + k];
    endfunction

    function automatic logic [127:0] subst_rows(logic [127:0] b, bit inverse);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (inverse)
                    t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = INV_BOX[byte_of(b, r + 4*c)];
                else
                    t[127 - 8*(r + 4*c) -: 8] = FWD_BOX[byte_of(b, r + 4*((c + r) % 4))];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix_state(logic [127:0] b, bit inverse);
        logic [7:0]   row[4];
        logic [7:0]   acc;
        logic [127:0] t;
        if (inverse) row = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else         row = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mul(byte_of(b, 4*c + k), row[(k - r + 4) % 4]);
                t[127 - 8*(4*c + r) -: 8] = acc;
            end
        return t;
    endfunction

    function automatic logic [127:0] cipher_block(logic [127:0] key, logic op,
                                                  logic [127:0] blk);
        logic [127:0] rk[11];
        derive_round_keys(key, rk);
        if (op == OP_ENCRYPT) begin
            blk ^= rk[0];
            for (int r = 1; r < 10; r++)
                blk = mix_state(subst_rows(blk, 1'b0), 1'b0) ^ rk[r];
            blk = subst_rows(blk, 1'b0) ^ rk[10];
        end else begin
            blk ^= rk[10];
            for (int r = 9; r >= 1; r--)
                blk = mix_state(subst_rows(blk, 1'b1) ^ rk[r], 1'b1);
            blk = subst_rows(blk, 1'b1) ^ rk[0];
        end
        return blk;
    endfunction

    // ---------------- Drivers ----------------

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Offers one register write and holds it until the transaction completes.
    task automatic write_key_reg(logic index, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_KEY_UPPER) model_key[127:64] = value;
        else                        model_key[63:0]   = value;
    endtask

    // Register writes happen only with the pipeline drained.
    task automatic load_key(logic [63:0] upper, logic [63:0] lower);
        write_key_reg(CFG_KEY_UPPER, upper);
        write_key_reg(CFG_KEY_LOWER, lower);
        i_cfg_valid <= 1'b0;
    endtask

    // Offers one block and holds it until the transaction completes.
    task automatic send_block(logic op, logic [63:0] upper, logic [63:0] lower);
        if (!calm_mode) begin
            while ($urandom_range(99) < 13) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_data_upper <= upper;
        i_data_lower <= lower;
        do @(posedge i_clk); while (!o_ready);
        board.note_block(cipher_block(model_key, op, {upper, lower}));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Receiver: random ready, long hold-off when asked, checks every result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) board.check_block(o_out_upper, o_out_lower);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= calm_mode || ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("** aes128_block_cipher: FAILED **");
            $finish;
        end
    end

    // ---------------- Stimulus ----------------

    initial begin
        logic [63:0] ku, kl;
        board        = new();
        model_key    = '0;
        cycle_count  = 0;
        calm_mode    = 1'b0;
        hold_off     = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_opcode     = OP_ENCRYPT;
        i_data_upper = '0;
        i_data_lower = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_KEY_UPPER;
        i_cfg_data   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset key of all zeros, then extreme data patterns both ways.
        send_block(OP_ENCRYPT, '0, '0);
        send_block(OP_DECRYPT, '0, '0);
        send_block(OP_ENCRYPT, '1, '1);
        send_block(OP_DECRYPT, '1, '1);
        wait_drained();

        // Standard test vector key, with the matching plaintext.
        load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(OP_ENCRYPT, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(OP_DECRYPT, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
        send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        send_block(OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        wait_drained();

        // All-ones key.
        load_key('1, '1);
        send_block(OP_ENCRYPT, '0, '1);
        send_block(OP_DECRYPT, '1, '0);
        send_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        wait_drained();

        // Random phases, each under a fresh key. Phase 1 runs without idling
        // and starts with a long receiver hold-off so the pipeline fills up.
        for (int phase = 0; phase < 6; phase++) begin
            ku = rand64();
            kl = rand64();
            load_key(ku, kl);
            calm_mode = (phase == 1);
            if (phase == 1) hold_off = 60;
            for (int n = 0; n < NUM_RANDOM / 6; n++)
                send_block(1'($urandom_range(1)), rand64(), rand64());
            // The sender pauses here until every result has come back.
            wait_drained();
        end
        calm_mode = 1'b0;

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("** aes128_block_cipher: PASSED **");
        end else begin
            $display("** aes128_block_cipher: FAILED **");
        end
        $finish;
    end
endmodule
